// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define BUR_ASSERT_NOW(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bur check failed");

// next-cycle implication, checked outside reset
`define BUR_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bur check failed");

`endif

// ----- rtl/bur_pkg.sv -----
package bur_pkg;

    // history geometry
    localparam int HISTORY_LIMIT = 20;
    localparam int DEPTH         = HISTORY_LIMIT + 1;
    localparam int PTR_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);

    // field widths
    localparam int STATE_BITS = 64;
    localparam int TIME_W     = 32;
    localparam int FUNC_W     = 3;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLLISION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 1'd1;
    localparam logic [TIME_W-1:0]    INTERVAL_RESET = 32'd800;

    // request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_RECORD = 3'd0,
        FUNC_UNDO   = 3'd1,
        FUNC_REDO   = 3'd2,
        FUNC_PURGE  = 3'd3,
        FUNC_QUERY  = 3'd4
    } t_func;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

endpackage

// ----- rtl/bur_in_if.sv -----
interface bur_in_if import bur_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FUNC_W-1:0]     func;
    logic [STATE_BITS-1:0] entry_in;
    logic [TIME_W-1:0]     now_ms;

    modport source (output valid, output func, output entry_in, output now_ms, input ready);
    modport sink (input valid, input func, input entry_in, input now_ms, output ready);
endinterface

// ----- rtl/bur_out_if.sv -----
interface bur_out_if import bur_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATE_BITS-1:0] state_out;
    logic                  from_history;
    logic                  recorded;
    logic                  can_undo;
    logic [CNT_W-1:0]      entries_used;
    logic                  modified;

    modport source (output valid, output state_out, output from_history, output recorded,
                    output can_undo, output entries_used, output modified, input ready);
    modport sink (input valid, input state_out, input from_history, input recorded,
                  input can_undo, input entries_used, input modified, output ready);
endinterface

// ----- rtl/bur_ctrl.sv -----
module bur_ctrl import bur_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;

    // a new request enters when idle or as the held result leaves
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = accept ? S_EXEC : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (n_state == S_DONE);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = accept;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

// ----- rtl/bur_dp.sv -----
module bur_dp import bur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [STATE_BITS-1:0] i_entry_in,
    input  logic [TIME_W-1:0]     i_now_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [STATE_BITS-1:0] o_state_out,
    output logic                  o_from_history,
    output logic                  o_recorded,
    output logic                  o_can_undo,
    output logic [CNT_W-1:0]      o_entries_used,
    output logic                  o_modified
);

    // circular pointer helpers, sum stays below twice the depth
    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [PTR_W:0] s);
        return (s >= (PTR_W+1)'(DEPTH)) ? PTR_W'(s - (PTR_W+1)'(DEPTH)) : s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
    endfunction

    // captured request
    logic [FUNC_W-1:0]     r_func;
    logic [STATE_BITS-1:0] r_word;
    logic [TIME_W-1:0]     r_now;

    // history control state
    logic [PTR_W-1:0]  r_fp, n_fp;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [PTR_W-1:0]  r_cur, n_cur;
    logic [TIME_W-1:0] r_last, n_last;
    logic              r_seen, n_seen;

    // configuration
    logic              r_cv;
    logic [TIME_W-1:0] r_interval;

    // result flags
    logic r_from_hist, n_from_hist;
    logic r_recorded, n_recorded;

    // history storage
    logic [STATE_BITS-1:0] r_mem [DEPTH];
    logic [STATE_BITS-1:0] r_rdata;
    logic                  mem_we;
    logic [PTR_W-1:0]      waddr;
    logic [PTR_W-1:0]      raddr;

    // record helpers
    logic [TIME_W-1:0] gap;
    logic              drop;
    logic [PTR_W-1:0]  base_fp;
    logic [CNT_W-1:0]  base_cnt;
    logic [CNT_W-1:0]  grown_cnt;
    logic [CNT_W-1:0]  cur_up;
    logic [CNT_W-1:0]  cur_lim;

    // coalescing check with modular time
    assign gap  = r_now - r_last;
    assign drop = r_seen && (gap < r_interval);

    // discard undone entries ahead of a record
    assign base_fp  = (r_cur != '0)
                    ? ptr_wrap((PTR_W+1)'(r_fp) + (PTR_W+1)'(r_cur) + (PTR_W+1)'(1))
                    : r_fp;
    assign base_cnt = (r_cur != '0) ? CNT_W'(r_cnt - CNT_W'(r_cur) - CNT_W'(1)) : r_cnt;
    assign grown_cnt = (base_cnt < CNT_W'(DEPTH)) ? CNT_W'(base_cnt + 1'b1) : base_cnt;

    // next history state
    always_comb begin
        n_fp        = r_fp;
        n_cnt       = r_cnt;
        n_cur       = r_cur;
        n_last      = r_last;
        n_seen      = r_seen;
        n_from_hist = 1'b0;
        n_recorded  = 1'b0;
        mem_we      = 1'b0;
        waddr       = r_fp;
        raddr       = r_fp;
        cur_up      = CNT_W'(r_cur) + CNT_W'(1);
        cur_lim     = '0;
        case (r_func)
            FUNC_RECORD: begin
                n_last = r_now;
                n_seen = 1'b1;
                if (!drop) begin
                    mem_we     = 1'b1;
                    waddr      = ptr_dec(base_fp);
                    n_fp       = waddr;
                    n_cnt      = (grown_cnt > CNT_W'(HISTORY_LIMIT))
                               ? CNT_W'(HISTORY_LIMIT) : grown_cnt;
                    n_cur      = '0;
                    n_recorded = 1'b1;
                end
            end
            FUNC_UNDO: begin
                if (r_cnt != '0) begin
                    // first step saves the live word
                    if (r_cur == '0) begin
                        mem_we = 1'b1;
                        waddr  = ptr_dec(r_fp);
                        n_fp   = waddr;
                        n_cnt  = (r_cnt < CNT_W'(DEPTH)) ? CNT_W'(r_cnt + 1'b1) : r_cnt;
                    end
                    cur_lim     = CNT_W'(n_cnt - 1'b1);
                    n_cur       = (cur_up > cur_lim) ? PTR_W'(cur_lim) : PTR_W'(cur_up);
                    raddr       = ptr_wrap((PTR_W+1)'(n_fp) + (PTR_W+1)'(n_cur));
                    n_from_hist = 1'b1;
                end
            end
            FUNC_REDO: begin
                if ((r_cnt != '0) && (r_cur != '0)) begin
                    n_cur       = PTR_W'(r_cur - 1'b1);
                    raddr       = ptr_wrap((PTR_W+1)'(r_fp) + (PTR_W+1)'(n_cur));
                    n_from_hist = 1'b1;
                    // back at the live word: drop the saved copy
                    if (n_cur == '0) begin
                        n_fp  = ptr_inc(r_fp);
                        n_cnt = CNT_W'(r_cnt - 1'b1);
                    end
                end
            end
            FUNC_PURGE: begin
                if (!r_cv) begin
                    n_cur = '0;
                    n_cnt = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_word <= i_entry_in;
            r_now  <= i_now_ms;
        end
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp        <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_cv        <= 1'b0;
            r_interval  <= INTERVAL_RESET;
            r_from_hist <= 1'b0;
            r_recorded  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COLLISION: r_cv       <= i_cfg_data[0];
                    CFG_INTERVAL:  r_interval <= i_cfg_data[TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec) begin
                r_fp        <= n_fp;
                r_cnt       <= n_cnt;
                r_cur       <= n_cur;
                r_last      <= n_last;
                r_seen      <= n_seen;
                r_from_hist <= n_from_hist;
                r_recorded  <= n_recorded;
            end
        end
    end

    // history memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (mem_we) begin
                r_mem[waddr] <= r_word;
            end
            r_rdata <= r_mem[raddr];
        end
    end

    // result fields
    assign o_state_out    = r_from_hist ? r_rdata : r_word;
    assign o_from_history = r_from_hist;
    assign o_recorded     = r_recorded;
    assign o_can_undo     = (r_cnt != '0)
                         && ((r_cnt == CNT_W'(1)) || (CNT_W'(r_cur) != CNT_W'(r_cnt - 1'b1)));
    assign o_entries_used = r_cnt;
    assign o_modified     = r_seen;

endmodule

// ----- rtl/bounded_undo_redo_history.sv -----
// bounded undo/redo history of state words
// an accepted request passes through the execute state; its result is then registered valid
// and held until taken
// a new request enters when idle or in the cycle its predecessor's result is taken, not
// before; the execute state holds the registered read of the history memory
// reset: synchronous, active low; clears pointers, counters and flags, returns configuration
// to its reset values, history storage keeps its contents and needs no clearing
module bounded_undo_redo_history import bur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bur_in_if.sink                i_in,
    bur_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // handshake sequencing
    bur_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // history state and storage
    bur_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_in.func),
        .i_entry_in     (i_in.entry_in),
        .i_now_ms       (i_in.now_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_state_out    (o_out.state_out),
        .o_from_history (o_out.from_history),
        .o_recorded     (o_out.recorded),
        .o_can_undo     (o_out.can_undo),
        .o_entries_used (o_out.entries_used),
        .o_modified     (o_out.modified)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

// ----- rtl/bur_chk.sv -----
`include "assert_macros.svh"

module bur_chk import bur_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_recorded,
    input logic             i_from_history,
    input logic             i_can_undo,
    input logic             i_modified,
    input logic [CNT_W-1:0] i_entries_used
);

    // a waiting result stays valid
    `BUR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // an accepted request keeps the block busy for its execute cycle
    `BUR_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready && !i_out_valid)

    // undo possible only with history held
    `BUR_ASSERT_NOW(a_undo_needs_entries, i_clk, i_rst_n, i_out_valid && i_can_undo, i_entries_used != '0)

    // a pushed record marks the block modified and never reads history
    `BUR_ASSERT_NOW(a_record_flags, i_clk, i_rst_n, i_out_valid && i_recorded, i_modified && !i_from_history && (i_entries_used != '0))

    // fill never exceeds the storage depth
    `BUR_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, i_out_valid, i_entries_used <= CNT_W'(DEPTH))

endmodule

bind bounded_undo_redo_history bur_chk u_bur_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_recorded     (o_out.recorded),
    .i_from_history (o_out.from_history),
    .i_can_undo     (o_out.can_undo),
    .i_modified     (o_out.modified),
    .i_entries_used (o_out.entries_used)
);
